### hw/rtl/fqs_pkg.sv
`default_nettype none

package fqs_pkg;

  // Action codes of a command request
  localparam logic [1:0] ACT_PUSH   = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;

  // Status codes of a result request
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_MATCH   = 3'd3;
  localparam logic [2:0] ST_NOMATCH = 3'd4;

  // Cell operations broadcast along the chain
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_PUSH   = 2'd1;
  localparam logic [1:0] CELL_SHIFT  = 2'd2;
  localparam logic [1:0] CELL_ROTATE = 2'd3;

  localparam logic signed [31:0] POP_EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] data;
  } cmd_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] value;
    logic [6:0]         position;
    logic signed [31:0] next_value;
    logic               has_next;
    logic               run_end;
    logic               queue_empty;
    logic signed [31:0] front_value;
    logic [6:0]         occupancy;
  } res_req_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] push_data;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/fqs_cell.sv
`default_nettype none

module fqs_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  wire                       clk,
  input  fqs_pkg::cell_ctrl_t       ctrl,
  input  wire logic signed [31:0]   from_next,
  input  wire logic signed [31:0]   from_front,
  input  wire logic [CNT_W-1:0]     count,
  output logic signed [31:0]        value
);
  import fqs_pkg::*;

  localparam logic [CNT_W-1:0] IDX     = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] IDX_INC = CNT_W'(INDEX + 1);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_PUSH: begin
        if (count == IDX) begin
          value <= ctrl.push_data;
        end
      end
      CELL_SHIFT: begin
        value <= from_next;
      end
      CELL_ROTATE: begin
        // tail cell takes the front, occupied cells ahead of it advance
        if (IDX_INC == count) begin
          value <= from_front;
        end else if (IDX_INC < count) begin
          value <= from_next;
        end
      end
      default: begin
        value <= value;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/fifo_queue_with_value_search.sv
`default_nettype none

// FIFO queue of signed 32-bit values with a value search.
// Command channel (cmd_valid / cmd_stall / cmd): action push, pop or search
// and a data word (value to push or key to search for). Result channel
// (res_valid / res_stall / res): status, value, match position, following
// entry, run_end on the last result of a command, and the queue state
// (empty flag, front value, occupancy) after the command.
// For push, pop and unused actions the result is registered and
// appears the cycle after the command is taken, and a new command can be
// taken every cycle while the result side keeps up.
// A search walks the stored entries one per cycle, unless paused as below, by
// rotating the cell chain; it holds cmd_stall high until the walk ends and
// emits one result per match (or one empty / no-match result).
// Reset empties the queue; stored values need no clearing.
// While res_stall is high the held result stays put, cmd_stall rises and a
// search in progress pauses once it has a further match to hand on or has
// reached the end of its walk.
module fifo_queue_with_value_search #(
  parameter int DEPTH = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                cmd_valid,
  output logic               cmd_stall,
  input  fqs_pkg::cmd_req_t  cmd,
  output logic               res_valid,
  input  wire                res_stall,
  output fqs_pkg::res_req_t  res
);
  import fqs_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE        = CW'(1);

  // Queue state: cell 0 holds the front entry except while a search rotates the chain
  logic signed [31:0] cell_val [DEPTH];
  logic [CW-1:0]      count;
  cell_ctrl_t         cell_ctrl;

  // Search walk state
  logic               busy;
  logic [CW-1:0]      step;
  logic signed [31:0] key;
  logic signed [31:0] front_hold;

  // Last match seen, held until the next match or the end of the walk
  logic               pend_valid;
  logic [6:0]         pend_pos;
  logic signed [31:0] pend_next;
  logic               pend_has_next;

  logic       res_free;
  logic       cmd_acc;
  logic       at_end;
  logic       hit;
  logic       step_go;
  logic       emit_mid;
  logic       finish;
  logic       load_now;
  logic [CW-1:0] step_inc;
  logic       more;
  res_req_t   res_next;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [31:0] nbr;
      if (gi == DEPTH - 1) begin : g_last
        assign nbr = cell_val[gi];
      end else begin : g_mid
        assign nbr = cell_val[gi + 1];
      end
      fqs_cell #(
        .INDEX (gi),
        .CNT_W (CW)
      ) u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl),
        .from_next  (nbr),
        .from_front (cell_val[0]),
        .count      (count),
        .value      (cell_val[gi])
      );
    end
  endgenerate

  assign res_free  = !res_valid || !res_stall;
  assign cmd_stall = busy || !res_free;
  assign cmd_acc   = cmd_valid && !cmd_stall;

  assign at_end   = (step == count);
  assign hit      = (cell_val[0] == key);
  assign step_go  = busy && !at_end && (!(hit && pend_valid) || res_free);
  assign emit_mid = step_go && hit && pend_valid;
  assign finish   = busy && at_end && res_free;
  assign step_inc = step + ONE;
  assign more     = (step_inc < count);

  // Broadcast one operation down the chain
  always_comb begin
    cell_ctrl.op        = CELL_HOLD;
    cell_ctrl.push_data = cmd.data;
    if (cmd_acc && cmd.action == ACT_PUSH && count != FULL_COUNT) begin
      cell_ctrl.op = CELL_PUSH;
    end else if (cmd_acc && cmd.action == ACT_POP && count != '0) begin
      cell_ctrl.op = CELL_SHIFT;
    end else if (step_go) begin
      cell_ctrl.op = CELL_ROTATE;
    end
  end

  // Build the next result request
  always_comb begin
    load_now             = 1'b0;
    res_next.status      = ST_DONE;
    res_next.value       = '0;
    res_next.position    = '0;
    res_next.next_value  = '0;
    res_next.has_next    = 1'b0;
    res_next.run_end     = 1'b1;
    res_next.queue_empty = (count == '0);
    res_next.front_value = (count == '0) ? 32'sd0 : cell_val[0];
    res_next.occupancy   = 7'(count);

    if (busy) begin
      // Search in progress: queue state is that held at the start
      res_next.front_value = front_hold;
      res_next.queue_empty = 1'b0;
      if (emit_mid || (finish && pend_valid)) begin
        load_now            = 1'b1;
        res_next.status     = ST_MATCH;
        res_next.value      = key;
        res_next.position   = pend_pos;
        res_next.next_value = pend_next;
        res_next.has_next   = pend_has_next;
        res_next.run_end    = finish;
      end else if (finish) begin
        load_now        = 1'b1;
        res_next.status = ST_NOMATCH;
      end
    end else if (cmd_acc) begin
      case (cmd.action)
        ACT_PUSH: begin
          load_now = 1'b1;
          if (count == FULL_COUNT) begin
            res_next.status = ST_FULL;
          end else begin
            res_next.queue_empty = 1'b0;
            res_next.front_value = (count == '0) ? cmd.data : cell_val[0];
            res_next.occupancy   = 7'(count + ONE);
          end
        end
        ACT_POP: begin
          load_now = 1'b1;
          if (count == '0) begin
            res_next.status = ST_EMPTY;
            res_next.value  = POP_EMPTY_VALUE;
          end else begin
            res_next.value       = cell_val[0];
            res_next.queue_empty = (count == ONE);
            res_next.front_value = (count > ONE) ? cell_val[1] : 32'sd0;
            res_next.occupancy   = 7'(count - ONE);
          end
        end
        ACT_SEARCH: begin
          // a non-empty queue starts the walk instead
          if (count == '0) begin
            load_now        = 1'b1;
            res_next.status = ST_EMPTY;
          end
        end
        default: begin
          load_now = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      busy       <= 1'b0;
      step       <= '0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (cell_ctrl.op == CELL_PUSH) begin
        count <= count + ONE;
      end else if (cell_ctrl.op == CELL_SHIFT) begin
        count <= count - ONE;
      end

      if (cmd_acc && cmd.action == ACT_SEARCH && count != '0) begin
        busy       <= 1'b1;
        step       <= '0;
        pend_valid <= 1'b0;
      end else if (step_go) begin
        step <= step_inc;
        if (hit) begin
          pend_valid <= 1'b1;
        end
      end else if (finish) begin
        busy       <= 1'b0;
        pend_valid <= 1'b0;
      end

      if (load_now) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_acc && cmd.action == ACT_SEARCH) begin
      key        <= cmd.data;
      front_hold <= cell_val[0];
    end
    if (step_go && hit) begin
      pend_pos      <= 7'(step_inc);
      pend_has_next <= more;
      pend_next     <= more ? cell_val[1] : 32'sd0;
    end
    if (load_now) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire
